// ===== hw/rtl/ksd_pkg.sv =====
// ksd_pkg: shared types and codes of the key sequence trigger detector
// no dependencies; compiled first

package ksd_pkg;

   typedef enum logic {
      CMD_KEY  = 1'b0,
      CMD_TICK = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      KEY_PRIMARY   = 2'd0,
      KEY_SECONDARY = 2'd1,
      KEY_HOLD      = 2'd2,
      KEY_OTHER     = 2'd3
   } key_type;

   // sequence phases, reported as is on the result channel
   localparam logic [1:0] PHASE_FIRST  = 2'd0;
   localparam logic [1:0] PHASE_SECOND = 2'd1;
   localparam logic [1:0] PHASE_THIRD  = 2'd2;
   localparam logic [1:0] PHASE_DONE   = 2'd3;

   // control register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 20;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_COUNT   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECOND_COUNT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_THIRD_COUNT   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_TICKS = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_ALWAYS   = 3'd4;

   localparam logic [3:0]  FIRST_COUNT_RST   = 4'd9;
   localparam logic [3:0]  SECOND_COUNT_RST  = 4'd5;
   localparam logic [3:0]  THIRD_COUNT_RST   = 4'd3;
   localparam logic [19:0] TIMEOUT_TICKS_RST = 20'd5000;

   typedef struct packed {
      logic [3:0]  first_count;
      logic [3:0]  second_count;
      logic [3:0]  third_count;
      logic [19:0] timeout_ticks;
      logic        hold_always;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  phase;
      logic [3:0]  presses;
      logic        hold_down;
      logic [19:0] time_left;
      logic        timer_on;
      logic        fired;
   } state_type;

   typedef struct packed {
      cmd_type cmd;
      key_type key;
      logic    down;
   } req_type;

   typedef struct packed {
      logic       fired;
      logic       handled;
      logic [1:0] phase;
      logic [3:0] presses;
      logic       timer_active;
   } rsp_type;

endpackage

// ===== hw/rtl/ksd_if.sv =====
// ksd_req_if / ksd_rsp_if: valid/ready channels of the detector
// depends on ksd_pkg

interface ksd_req_if;
   import ksd_pkg::*;

   logic    valid;
   logic    ready;
   cmd_type cmd;
   key_type key;
   logic    down;

   modport source (output valid, output cmd, output key, output down, input ready);
   modport sink   (input valid, input cmd, input key, input down, output ready);
endinterface

interface ksd_rsp_if;
   logic       valid;
   logic       ready;
   logic       fired;
   logic       handled;
   logic [1:0] phase;
   logic [3:0] presses;
   logic       timer_active;

   modport source (output valid, output fired, output handled, output phase,
                   output presses, output timer_active, input ready);
   modport sink   (input valid, input fired, input handled, input phase,
                   input presses, input timer_active, output ready);
endinterface

// ===== hw/rtl/key_sequence_trigger_detector_unit.sv =====
// key_sequence_trigger_detector_unit: top level of the key sequence trigger detector
// depends on ksd_pkg, ksd_if (ksd_req_if, ksd_rsp_if) and ksd_step
//
//   channel   | dir | handshake    | payload
//   ----------+-----+--------------+------------------------------------------
//   req_chan  | in  | valid/ready  | cmd, key, down
//   rsp_chan  | out | valid/ready  | fired, handled, phase, presses, timer_active
//   csr_*     | in  | write enable | csr_index selects register, csr_wdata value
//
// one transaction per cycle while rsp_chan does not stall: the step logic runs in the
// cycle a request is accepted and its response lands in the output register at that same edge
// req_chan.ready is high while the output register is empty or being drained,
// so a stalled rsp_chan holds exactly one response and then back-pressures
// reset (synchronous, active high) clears progress, timer and fired flag and
// loads the default counts 9/5/3, timeout 5000 ticks, hold key honored

module key_sequence_trigger_detector_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   ksd_req_if.sink                              req_chan,
   ksd_rsp_if.source                            rsp_chan,
   input  logic                                 csr_we,
   input  logic [ksd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [ksd_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import ksd_pkg::*;

   cfg_type   cfg_ff,   cfg_in;
   state_type state_ff, state_in;
   rsp_type   rsp_ff;
   logic      rsp_valid_ff, rsp_valid_in;

   req_type   item;
   state_type step_state;
   rsp_type   step_rsp;
   logic      accept;

   // request side: free when the output register is empty or emptying
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign item.cmd  = req_chan.cmd;
   assign item.key  = req_chan.key;
   assign item.down = req_chan.down;

   ksd_step u_step (
      .cfg    (cfg_ff),
      .cur    (state_ff),
      .item   (item),
      .nxt    (step_state),
      .result (step_rsp)
   );

   // control register writes, out of range indexes ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FIRST_COUNT:   cfg_in.first_count   = csr_wdata[3:0];
            CSR_SECOND_COUNT:  cfg_in.second_count  = csr_wdata[3:0];
            CSR_THIRD_COUNT:   cfg_in.third_count   = csr_wdata[3:0];
            CSR_TIMEOUT_TICKS: cfg_in.timeout_ticks = csr_wdata[19:0];
            CSR_HOLD_ALWAYS:   cfg_in.hold_always   = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // sequence state advances only on an accepted transaction
   assign state_in = accept ? step_state : state_ff;

   // output register valid: loads on accept, drains on rsp handshake
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_count   <= FIRST_COUNT_RST;
         cfg_ff.second_count  <= SECOND_COUNT_RST;
         cfg_ff.third_count   <= THIRD_COUNT_RST;
         cfg_ff.timeout_ticks <= TIMEOUT_TICKS_RST;
         cfg_ff.hold_always   <= 1'b0;
         state_ff             <= '0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.fired        = rsp_ff.fired;
   assign rsp_chan.handled      = rsp_ff.handled;
   assign rsp_chan.phase        = rsp_ff.phase;
   assign rsp_chan.presses      = rsp_ff.presses;
   assign rsp_chan.timer_active = rsp_ff.timer_active;

endmodule

// ===== hw/rtl/ksd_step.sv =====
// ksd_step: next state and result for one transaction of the detector
// depends on ksd_pkg; purely combinational

module ksd_step (
   input  ksd_pkg::cfg_type   cfg,
   input  ksd_pkg::state_type cur,
   input  ksd_pkg::req_type   item,
   output ksd_pkg::state_type nxt,
   output ksd_pkg::rsp_type   result
);
   import ksd_pkg::*;

   function automatic logic [3:0] phase_need(input cfg_type c, input logic [1:0] ph);
      logic [3:0] n;
      begin
         if (ph == PHASE_FIRST) begin
            n = c.first_count;
         end else if (ph == PHASE_SECOND) begin
            n = c.second_count;
         end else begin
            n = c.third_count;
         end
         phase_need = (n == 4'd0) ? 4'd1 : n;
      end
   endfunction

   key_type    want_key;
   logic       match;
   logic       counts;
   logic [1:0] base_phase;
   logic [3:0] base_presses;
   logic [3:0] bumped;
   logic [3:0] need;
   logic       handled;

   // a press of the wrong key restarts from scratch; a primary press then counts
   assign want_key     = (cur.phase == PHASE_SECOND) ? KEY_SECONDARY : KEY_PRIMARY;
   assign match        = (item.key == want_key);
   assign counts       = match || (item.key == KEY_PRIMARY);
   assign base_phase   = match ? cur.phase : PHASE_FIRST;
   assign base_presses = match ? cur.presses : 4'd0;
   assign bumped       = base_presses + 4'd1;
   assign need         = phase_need(cfg, base_phase);

   always_comb begin
      nxt     = cur;
      handled = 1'b0;
      if (!cur.fired) begin
         if (item.cmd == CMD_TICK) begin
            if (cur.timer_on) begin
               if (cur.time_left <= 20'd1) begin
                  nxt.time_left = '0;
                  nxt.timer_on  = 1'b0;
                  nxt.phase     = PHASE_FIRST;
                  nxt.presses   = '0;
               end else begin
                  nxt.time_left = cur.time_left - 20'd1;
               end
            end
         end else begin
            unique case (item.key) inside
               KEY_HOLD: begin
                  if (!cfg.hold_always) begin
                     nxt.hold_down = item.down;
                     if (!item.down) begin
                        nxt.phase   = PHASE_FIRST;
                        nxt.presses = '0;
                     end
                  end
               end
               KEY_PRIMARY, KEY_SECONDARY: begin
                  handled = 1'b1;
                  if (item.down && (cfg.hold_always || cur.hold_down)) begin
                     if (!match) begin
                        nxt.timer_on = 1'b0;
                        nxt.phase    = PHASE_FIRST;
                        nxt.presses  = '0;
                     end
                     if (counts) begin
                        // the first counted press arms the timeout
                        if (base_phase == PHASE_FIRST && base_presses == 4'd0) begin
                           nxt.time_left = cfg.timeout_ticks;
                           nxt.timer_on  = 1'b1;
                        end
                        if (bumped >= need) begin
                           nxt.presses = '0;
                           if (base_phase >= PHASE_THIRD) begin
                              nxt.phase     = PHASE_DONE;
                              nxt.fired     = 1'b1;
                              nxt.timer_on  = 1'b0;
                              nxt.time_left = '0;
                           end else begin
                              nxt.phase = base_phase + 2'd1;
                           end
                        end else begin
                           nxt.presses = bumped;
                           nxt.phase   = base_phase;
                        end
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign result.fired        = nxt.fired;
   assign result.handled      = handled;
   assign result.phase        = nxt.phase;
   assign result.presses      = nxt.presses;
   assign result.timer_active = nxt.timer_on;

endmodule

// ===== sim/testbench.sv =====
// testbench: self-checking bench for key_sequence_trigger_detector_unit
// depends on ksd_pkg and ksd_if (ksd_req_if, ksd_rsp_if) from the rtl
// a sequence predictor in the bench computes every status; directed and random tests

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ksd_pkg::*;

   // index values beyond the register map, written to show they are ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_LOW  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_HIGH = 3'd7;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   ksd_req_if req_chan ();
   ksd_rsp_if rsp_chan ();

   key_sequence_trigger_detector_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor copy of the detector registers and sequence state
   cfg_type     det_cfg;
   logic [1:0]  seq_phase;
   logic [3:0]  seq_presses;
   logic        hold_is_down;
   logic [19:0] ticks_left;
   logic        timer_running;
   logic        has_fired;

   // statuses predicted at request acceptance, oldest first
   rsp_type expected_status_q[$];
   int      mismatch_count = 0;

   // traffic shaping knobs, changed between test phases
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int rsp_holdoff_cycles = 0;
   int holdoff_requests   = 0;

   // hold-off bookkeeping owned by the receiver process
   int holdoff_served = 0;
   int holdoff_left   = 0;

   // presses that close a phase; a count of zero behaves as one
   function automatic int presses_needed(logic [1:0] ph);
      logic [3:0] n;
      if (ph == PHASE_FIRST)
         n = det_cfg.first_count;
      else if (ph == PHASE_SECOND)
         n = det_cfg.second_count;
      else
         n = det_cfg.third_count;
      return (n == 4'd0) ? 1 : int'(n);
   endfunction

   // a counted press: wrong key drops progress, a wrong primary restarts phase one
   function automatic void count_key_press(key_type k);
      key_type wanted;
      wanted = (seq_phase == PHASE_SECOND) ? KEY_SECONDARY : KEY_PRIMARY;
      if (k != wanted) begin
         timer_running = 1'b0;
         seq_phase     = PHASE_FIRST;
         seq_presses   = '0;
         if (k != KEY_PRIMARY)
            return;
      end
      // the first counted press arms the timeout
      if (seq_phase == PHASE_FIRST && seq_presses == 4'd0) begin
         ticks_left    = det_cfg.timeout_ticks;
         timer_running = 1'b1;
      end
      seq_presses = seq_presses + 4'd1;
      // >= so that a count lowered mid phase ends it on the next press
      if (int'(seq_presses) >= presses_needed(seq_phase)) begin
         seq_presses = '0;
         if (seq_phase >= PHASE_THIRD) begin
            seq_phase     = PHASE_DONE;
            has_fired     = 1'b1;
            timer_running = 1'b0;
            ticks_left    = '0;
         end else begin
            seq_phase = seq_phase + 2'd1;
         end
      end
   endfunction

   // advance the predicted detector by one request and return its status
   function automatic rsp_type advance_detector(cmd_type c, key_type k, logic d);
      rsp_type r;
      r.handled = 1'b0;
      if (!has_fired) begin
         if (c == CMD_TICK) begin
            if (timer_running) begin
               if (ticks_left <= 20'd1) begin
                  // expiry drops progress
                  ticks_left    = '0;
                  timer_running = 1'b0;
                  seq_phase     = PHASE_FIRST;
                  seq_presses   = '0;
               end else begin
                  ticks_left = ticks_left - 20'd1;
               end
            end
         end else if (k == KEY_HOLD) begin
            if (!det_cfg.hold_always) begin
               hold_is_down = d;
               // release drops progress but leaves the timer running
               if (!d) begin
                  seq_phase   = PHASE_FIRST;
                  seq_presses = '0;
               end
            end
         end else if (k == KEY_PRIMARY || k == KEY_SECONDARY) begin
            r.handled = 1'b1;
            if (d && (det_cfg.hold_always || hold_is_down))
               count_key_press(k);
         end
      end
      r.fired        = has_fired;
      r.phase        = seq_phase;
      r.presses      = seq_presses;
      r.timer_active = timer_running;
      return r;
   endfunction

   // response channel ready: random stalls plus an optional long hold-off
   always @(negedge clock) begin
      if (holdoff_served != holdoff_requests) begin
         holdoff_served = holdoff_requests;
         holdoff_left   = rsp_holdoff_cycles;
      end
      if (holdoff_left > 0) begin
         rsp_chan.ready <= 1'b0;
         holdoff_left = holdoff_left - 1;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // response checker: each accepted transaction against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_status_q.size() == 0) begin
            $error("response transaction with no request outstanding");
            mismatch_count++;
         end else begin
            want = expected_status_q.pop_front();
            if (rsp_chan.fired !== want.fired) begin
               $error("fired: expected %0d, got %0d", want.fired, rsp_chan.fired);
               mismatch_count++;
            end
            if (rsp_chan.handled !== want.handled) begin
               $error("handled: expected %0d, got %0d", want.handled, rsp_chan.handled);
               mismatch_count++;
            end
            if (rsp_chan.phase !== want.phase) begin
               $error("phase: expected %0d, got %0d", want.phase, rsp_chan.phase);
               mismatch_count++;
            end
            if (rsp_chan.presses !== want.presses) begin
               $error("presses: expected %0d, got %0d", want.presses, rsp_chan.presses);
               mismatch_count++;
            end
            if (rsp_chan.timer_active !== want.timer_active) begin
               $error("timer_active: expected %0d, got %0d",
                      want.timer_active, rsp_chan.timer_active);
               mismatch_count++;
            end
         end
      end
   end

   // offer one request transaction, with random idle cycles in front of it
   task automatic send_item(cmd_type c, key_type k, logic d);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.cmd   <= c;
      req_chan.key   <= k;
      req_chan.down  <= d;
      do
         @(posedge clock);
      while (!req_chan.ready);
      // accepted at this edge
      expected_status_q.push_back(advance_detector(c, k, d));
   endtask

   // stop offering and wait until every predicted status has come back
   task automatic wait_for_results();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (expected_status_q.size() != 0)
         @(posedge clock);
   endtask

   // one register write; only called while nothing is in flight
   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_FIRST_COUNT:   det_cfg.first_count   = value[3:0];
         CSR_SECOND_COUNT:  det_cfg.second_count  = value[3:0];
         CSR_THIRD_COUNT:   det_cfg.third_count   = value[3:0];
         CSR_TIMEOUT_TICKS: det_cfg.timeout_ticks = value[19:0];
         CSR_HOLD_ALWAYS:   det_cfg.hold_always   = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic configure(logic [3:0] first, logic [3:0] second, logic [3:0] third,
                            logic [19:0] timeout, logic hold_always);
      write_register(CSR_FIRST_COUNT, CSR_DATA_W'(first));
      write_register(CSR_SECOND_COUNT, CSR_DATA_W'(second));
      write_register(CSR_THIRD_COUNT, CSR_DATA_W'(third));
      write_register(CSR_TIMEOUT_TICKS, timeout);
      write_register(CSR_HOLD_ALWAYS, CSR_DATA_W'(hold_always));
   endtask

   // mostly the presses the current phase wants, some noise; never completes
   task automatic send_random_items(int count);
      cmd_type c;
      key_type k;
      logic    d;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 85) begin
            if (!(det_cfg.hold_always || hold_is_down)) begin
               send_item(CMD_KEY, KEY_HOLD, 1'b1);
               continue;
            end
            c = CMD_KEY;
            k = (seq_phase == PHASE_SECOND) ? KEY_SECONDARY : KEY_PRIMARY;
            d = 1'b1;
         end else begin
            c = cmd_type'($urandom_range(1));
            k = key_type'($urandom_range(3));
            d = 1'($urandom_range(1));
         end
         // firing is sticky, so the closing press becomes a wrong key instead
         if (c == CMD_KEY && k == KEY_PRIMARY && d && (det_cfg.hold_always || hold_is_down)
             && seq_phase == PHASE_THIRD
             && int'(seq_presses) + 1 >= presses_needed(PHASE_THIRD))
            k = KEY_SECONDARY;
         send_item(c, k, d);
      end
   endtask

   // reset values; hold key honored, ignored presses and releases
   task automatic test_hold_and_ignored_keys();
      send_item(CMD_KEY, KEY_PRIMARY, 1'b1);   // hold up: no effect, still handled
      send_item(CMD_KEY, KEY_HOLD, 1'b1);
      send_item(CMD_KEY, KEY_PRIMARY, 1'b1);   // first press arms the timer
      send_item(CMD_KEY, KEY_OTHER, 1'b1);
      send_item(CMD_KEY, KEY_PRIMARY, 1'b0);
      send_item(CMD_KEY, KEY_HOLD, 1'b0);      // progress drops, timer keeps going
      wait_for_results();
   endtask

   // zero count, lowered count mid phase, hold_always, unused indexes, expiry
   task automatic test_register_effects();
      configure(4'd0, 4'd15, 4'd15, 20'd2, 1'b1);
      write_register(CSR_UNUSED_LOW, '1);
      write_register(CSR_UNUSED_HIGH, '1);
      send_item(CMD_KEY, KEY_HOLD, 1'b0);      // ignored under hold_always
      send_item(CMD_KEY, KEY_PRIMARY, 1'b1);   // zero count acts as one
      send_item(CMD_KEY, KEY_SECONDARY, 1'b1);
      send_item(CMD_KEY, KEY_SECONDARY, 1'b1);
      wait_for_results();
      write_register(CSR_SECOND_COUNT, CSR_DATA_W'(4'd1));
      send_item(CMD_KEY, KEY_SECONDARY, 1'b1); // already past the new count
      send_item(CMD_TICK, KEY_PRIMARY, 1'b0);
      send_item(CMD_TICK, KEY_OTHER, 1'b1);    // expires at one tick left
      send_item(CMD_TICK, KEY_HOLD, 1'b1);     // timer stopped: nothing
      wait_for_results();
   endtask

   // wrong keys in each phase and expiry with a zero timeout
   task automatic test_wrong_keys();
      write_register(CSR_FIRST_COUNT, CSR_DATA_W'(4'd15));
      write_register(CSR_TIMEOUT_TICKS, '1);
      write_register(CSR_HOLD_ALWAYS, CSR_DATA_W'(1'b0));
      send_item(CMD_KEY, KEY_HOLD, 1'b1);
      send_item(CMD_KEY, KEY_PRIMARY, 1'b1);
      send_item(CMD_KEY, KEY_SECONDARY, 1'b1); // wrong in phase one: timer stops
      send_item(CMD_KEY, KEY_PRIMARY, 1'b1);
      wait_for_results();
      write_register(CSR_FIRST_COUNT, CSR_DATA_W'(4'd1));
      send_item(CMD_KEY, KEY_PRIMARY, 1'b1);
      send_item(CMD_KEY, KEY_PRIMARY, 1'b1);   // wrong in phase two: new first press
      send_item(CMD_KEY, KEY_SECONDARY, 1'b1);
      send_item(CMD_KEY, KEY_SECONDARY, 1'b1); // wrong in phase three
      wait_for_results();
      write_register(CSR_TIMEOUT_TICKS, '0);
      send_item(CMD_KEY, KEY_PRIMARY, 1'b1);
      send_item(CMD_TICK, KEY_PRIMARY, 1'b1);  // zero left: expires at once
      wait_for_results();
   endtask

   // long receiver hold-off fills the block; then the sender waits for all results
   task automatic test_backpressure();
      configure(4'd4, 4'd3, 4'd6, 20'd8, 1'b0);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      @(posedge clock);
      rsp_holdoff_cycles = 60;
      holdoff_requests++;
      send_random_items(40);
      wait_for_results();
      send_random_items(20);
      wait_for_results();
   endtask

   // random sequences over four register settings and four idle profiles
   task automatic test_random_sequences();
      int send_idle[4] = '{0, 61, 0, 35};
      int recv_idle[4] = '{0, 0, 61, 35};
      for (int p = 0; p < 4; p++) begin
         wait_for_results();
         case (p)
            0: configure(4'd15, 4'd15, 4'd15, '1, 1'b0);
            1: configure(4'd1, 4'd1, 4'd1, 20'($urandom_range(1, 6)), 1'b1);
            2: configure(4'($urandom_range(15)), 4'($urandom_range(15)),
                         4'($urandom_range(15)), 20'($urandom_range(3, 12)), 1'b0);
            default: configure(4'($urandom_range(1, 6)), 4'($urandom_range(1, 6)),
                               4'($urandom_range(1, 6)), 20'($urandom_range(2, 10)),
                               1'($urandom_range(1)));
         endcase
         send_idle_pct  = send_idle[p];
         recv_stall_pct = recv_idle[p];
         send_random_items(210);
      end
      wait_for_results();
   endtask

   // full sequence to the sticky flag, then everything is ignored
   task automatic test_completion();
      configure(4'd2, 4'd1, 4'd2, 20'd100, 1'b0);
      send_idle_pct  = 20;
      recv_stall_pct = 20;
      send_item(CMD_KEY, KEY_HOLD, 1'b0);
      send_item(CMD_KEY, KEY_HOLD, 1'b1);
      send_item(CMD_KEY, KEY_PRIMARY, 1'b1);
      send_item(CMD_KEY, KEY_PRIMARY, 1'b1);
      send_item(CMD_KEY, KEY_SECONDARY, 1'b1);
      send_item(CMD_KEY, KEY_PRIMARY, 1'b1);
      send_item(CMD_KEY, KEY_PRIMARY, 1'b1);   // completes
      send_item(CMD_TICK, KEY_PRIMARY, 1'b0);
      send_item(CMD_KEY, KEY_PRIMARY, 1'b1);
      send_item(CMD_KEY, KEY_SECONDARY, 1'b0);
      send_item(CMD_KEY, KEY_HOLD, 1'b0);
      send_item(CMD_KEY, KEY_OTHER, 1'b1);
      wait_for_results();
   endtask

   // run watchdog
   initial begin
      #2_000_000;
      $display("testbench failed");
      $finish;
   end

   initial begin
      // request and register inputs known from time zero
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = CSR_FIRST_COUNT;
      csr_wdata      = '0;
      req_chan.valid = 1'b0;
      req_chan.cmd   = CMD_KEY;
      req_chan.key   = KEY_PRIMARY;
      req_chan.down  = 1'b0;

      // predictor starts from the reset state
      det_cfg = '{first_count: FIRST_COUNT_RST, second_count: SECOND_COUNT_RST,
                  third_count: THIRD_COUNT_RST, timeout_ticks: TIMEOUT_TICKS_RST,
                  hold_always: 1'b0};
      seq_phase     = PHASE_FIRST;
      seq_presses   = '0;
      hold_is_down  = 1'b0;
      ticks_left    = '0;
      timer_running = 1'b0;
      has_fired     = 1'b0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_hold_and_ignored_keys();
      test_register_effects();
      test_wrong_keys();
      test_backpressure();
      test_random_sequences();
      test_completion();

      // keep clocking to catch any stray response transaction
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && expected_status_q.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
